// ===== sv/mexp_pkg.sv =====
// shared constants, types and state codes for the modular exponentiation block
// no dependencies; compiled first
`default_nettype none

package mexp_pkg;

  // width of every payload field on the ports
  localparam int FIELD_BITS = 64;
  // operand width used in the arithmetic (8..64), low bits of each field
  localparam int WORD_BITS = 64;
  localparam int CNT_BITS = $clog2(WORD_BITS);
  localparam int CFG_INDEX_BITS = 8;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam cfg_index_t REG_MODULUS = cfg_index_t'(0);
  localparam cfg_index_t REG_POWER = cfg_index_t'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_MUL_ACC,
    ST_MUL_SQ,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== sv/mexp_if.sv =====
// valid/ready channel interfaces: configuration writes, base words, residue words
// depends on mexp_pkg
`default_nettype none

interface mexp_cfg_if;
  logic valid;
  logic ready;
  mexp_pkg::cfg_index_t index;
  mexp_pkg::field_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface mexp_base_if;
  logic valid;
  logic ready;
  mexp_pkg::field_t base_value;
  modport source (output valid, output base_value, input ready);
  modport sink (input valid, input base_value, output ready);
endinterface

interface mexp_res_if;
  logic valid;
  logic ready;
  mexp_pkg::field_t residue;
  modport source (output valid, output residue, input ready);
  modport sink (input valid, input residue, output ready);
endinterface

`default_nettype wire

// ===== sv/mexp_mulmod.sv =====
// shift-and-add modular multiplier, one multiplier bit per cycle
// depends on mexp_pkg
`default_nettype none

module mexp_mulmod (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  mexp_pkg::word_t   x,
  input  mexp_pkg::word_t   y,
  input  mexp_pkg::word_t   m,
  output logic              done,
  output mexp_pkg::word_t   product
);
  import mexp_pkg::*;

  logic  busy;
  word_t acc;
  word_t addend;
  word_t mult;

  // (a + b) mod md for a, b < md
  function automatic word_t add_mod(word_t a, word_t b, word_t md);
    logic [WORD_BITS:0] sum;
    logic [WORD_BITS:0] diff;
    sum = {1'b0, a} + {1'b0, b};
    diff = sum - {1'b0, md};
    if (sum >= {1'b0, md}) begin
      return diff[WORD_BITS-1:0];
    end
    return sum[WORD_BITS-1:0];
  endfunction

  // finished once the multiplier shift register has run out of set bits
  assign done = busy && (mult == '0);
  assign product = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      addend <= x;
      mult <= y;
    end else if (busy && (mult != '0)) begin
      if (mult[0]) begin
        acc <= add_mod(acc, addend, m);
      end
      addend <= add_mod(addend, addend, m);
      mult <= mult >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
// Computes base_value ^ power mod modulus, with modulus and power set through the
// configuration channel (indexes REG_MODULUS and REG_POWER); the user sets them only
// while the block is idle, which the block itself does not enforce. One word is in
// work at a time. The base is first reduced by a bit-serial restoring divider, then
// the exponent is scanned from its low bit; each set bit costs one modular multiply
// and every bit one squaring, all on the one shared shift-and-add multiplier, which
// steps through the significant bits of its multiplier. A modulus of 0 or 1 skips
// the divider and the multiplier and gives 0. The result sits in an output register,
// so the next base is taken while it waits to be read.
// depends on mexp_pkg, mexp_if, mexp_mulmod
`default_nettype none

module modular_exponentiation (
  input  logic      clk,
  input  logic      rst,
  mexp_cfg_if.sink  cfg,
  mexp_base_if.sink operand,
  mexp_res_if.source result
);
  import mexp_pkg::*;

  state_t state;
  state_t state_next;

  field_t modulus;
  field_t power;

  word_t m_op;
  word_t e_op;
  word_t bshift;
  word_t rem;
  word_t acc;
  word_t sq;
  cnt_t  cnt;

  logic   res_valid;
  field_t res_data;

  logic  mul_start;
  word_t mul_x;
  word_t mul_y;
  logic  mul_done;
  word_t mul_product;

  logic               in_accept;
  logic               mod_small;
  logic               finishing;
  logic [WORD_BITS:0] rem_shift;
  logic [WORD_BITS:0] rem_diff;
  word_t              rem_next;

  assign in_accept = operand.valid && operand.ready;
  assign mod_small = (modulus[WORD_BITS-1:1] == '0);
  assign finishing = (state == ST_FINISH) && (!res_valid || result.ready);

  // one restoring-division step per cycle
  assign rem_shift = {rem, bshift[WORD_BITS-1]};
  assign rem_diff = rem_shift - {1'b0, m_op};
  assign rem_next = (rem_shift >= {1'b0, m_op}) ? rem_diff[WORD_BITS-1:0]
                                                : rem_shift[WORD_BITS-1:0];

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= field_t'(1);
      power <= '0;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_MODULUS) begin
        modulus <= cfg.data;
      end else if (cfg.index == REG_POWER) begin
        power <= cfg.data;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = mod_small ? ST_FINISH : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (cnt == '0) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (e_op == '0) begin
          state_next = ST_FINISH;
        end else if (e_op[0]) begin
          state_next = ST_MUL_ACC;
        end else begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          state_next = ST_MUL_SQ;
        end
      end
      ST_MUL_SQ: begin
        if (mul_done) begin
          state_next = ST_SCAN;
        end
      end
      ST_FINISH: begin
        if (finishing) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and multiplier control
  always_comb begin
    operand.ready = 1'b0;
    mul_start = 1'b0;
    mul_x = sq;
    mul_y = sq;
    unique case (state)
      ST_IDLE: operand.ready = 1'b1;
      ST_SCAN: begin
        if (e_op != '0) begin
          mul_start = 1'b1;
          if (e_op[0]) begin
            mul_x = acc;
          end
        end
      end
      ST_MUL_ACC: mul_start = mul_done;
      ST_REDUCE, ST_MUL_SQ, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          m_op <= modulus[WORD_BITS-1:0];
          e_op <= power[WORD_BITS-1:0];
          bshift <= operand.base_value[WORD_BITS-1:0];
          rem <= '0;
          cnt <= cnt_t'(WORD_BITS - 1);
          acc <= '0;
        end
      end
      ST_REDUCE: begin
        rem <= rem_next;
        bshift <= bshift << 1;
        cnt <= cnt - cnt_t'(1);
        if (cnt == '0) begin
          sq <= rem_next;
          acc <= word_t'(1);
        end
      end
      ST_MUL_ACC: begin
        if (mul_done) begin
          acc <= mul_product;
        end
      end
      ST_MUL_SQ: begin
        if (mul_done) begin
          sq <= mul_product;
          e_op <= e_op >> 1;
        end
      end
      ST_SCAN, ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (finishing) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      res_data <= field_t'(acc);
    end
  end

  assign result.valid = res_valid;
  assign result.residue = res_data;

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x       (mul_x),
    .y       (mul_y),
    .m       (m_op),
    .done    (mul_done),
    .product (mul_product)
  );

endmodule

`default_nettype wire

// ===== dv/tb_modular_exponentiation.sv =====
// testbench for modular_exponentiation: directed and random base words under several
// configurations, checked against an in-bench square-and-multiply predictor
// depends on mexp_pkg, mexp_if and the rtl of modular_exponentiation
`timescale 1ns / 1ps

module tb_modular_exponentiation;
  import mexp_pkg::*;

  localparam cfg_index_t REG_UNMAPPED = '1;
  localparam int HOLD_CYCLES = 4000;
  localparam int DRAIN_LIMIT = 2000000;
  localparam int TAIL_CYCLES = 200;

  logic clk = 1'b0;
  logic rst;

  mexp_cfg_if cfg_ch();
  mexp_base_if base_ch();
  mexp_res_if res_ch();

  modular_exponentiation u_top (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .operand(base_ch),
    .result(res_ch)
  );

  always #5 clk = ~clk;

  // mirror of the configuration registers
  field_t modulus_reg = field_t'(1);
  field_t power_reg = '0;

  field_t expected_residues[$];
  field_t want_residue;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_active = 1'b0;

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    base_ch.valid = 1'b0;
    base_ch.base_value = '0;
    res_ch.ready = 1'b0;
  end

  // base ^ power mod modulus over the low WORD_BITS bits of each operand
  function automatic field_t modexp_residue(input field_t base_in);
    word_t m;
    word_t e;
    word_t acc;
    word_t sq;
    logic [2*WORD_BITS-1:0] prod;
    m = word_t'(modulus_reg);
    e = word_t'(power_reg);
    if (m <= word_t'(1)) return '0;
    acc = word_t'(1);
    sq = word_t'(base_in) % m;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (e[i]) begin
        prod = (2*WORD_BITS)'(acc) * (2*WORD_BITS)'(sq);
        acc = word_t'(prod % m);
      end
      prod = (2*WORD_BITS)'(sq) * (2*WORD_BITS)'(sq);
      sq = word_t'(prod % m);
    end
    return field_t'(acc);
  endfunction

  function automatic field_t rand64();
    return {$urandom, $urandom};
  endfunction

  // random value of exactly the given bit length
  function automatic field_t rand_bits(input int bits);
    field_t v;
    v = rand64();
    if (bits < FIELD_BITS) v &= (field_t'(1) << bits) - field_t'(1);
    v[bits-1] = 1'b1;
    return v;
  endfunction

  function automatic field_t pick_base();
    case ($urandom_range(9))
      0: return modulus_reg;
      1: return modulus_reg - field_t'(1);
      2: return field_t'($urandom_range(3));
      3: return '1;
      4: return modulus_reg + field_t'($urandom_range(5));
      default: return rand64();
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  task automatic write_reg(input cfg_index_t idx, input field_t value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_MODULUS: modulus_reg = value;
      REG_POWER: power_reg = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_base(input field_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      base_ch.valid <= 1'b0;
      @(negedge clk);
    end
    base_ch.valid <= 1'b1;
    base_ch.base_value <= b;
    @(posedge clk);
    while (!base_ch.ready) @(posedge clk);
    expected_residues = {expected_residues, modexp_residue(b)};
  endtask

  task automatic stop_base();
    @(negedge clk);
    base_ch.valid <= 1'b0;
  endtask

  task automatic wait_drain(input int max_cycles);
    int waited;
    waited = 0;
    while (expected_residues.size() != 0 && waited < max_cycles) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // finish the current burst and let every residue word come back
  task automatic settle();
    stop_base();
    wait_drain(DRAIN_LIMIT);
  endtask

  // long receiver hold-off, counted here so the sender keeps going
  initial begin
    forever begin
      wait (hold_request);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active = 1'b0;
      hold_request = 1'b0;
    end
  end

  always @(negedge clk) begin
    if (hold_active) res_ch.ready <= 1'b0;
    else res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_residues.size() == 0) begin
        report_mismatch($sformatf("unexpected residue word %h", res_ch.residue));
      end else begin
        want_residue = expected_residues.pop_front();
        if (res_ch.residue !== want_residue)
          report_mismatch($sformatf("residue %h, expected %h", res_ch.residue, want_residue));
      end
    end
  end

  // reset values: modulus one and power zero
  task automatic test_reset_values();
    send_base('0);
    send_base('1);
    send_base(rand64());
    settle();
  endtask

  task automatic test_special_cases();
    // modulus zero, outside the legal range, still returns zero
    write_reg(REG_MODULUS, '0);
    write_reg(REG_POWER, rand_bits(8));
    send_base(rand64());
    send_base('1);
    settle();
    // modulus one with every exponent bit set
    write_reg(REG_MODULUS, field_t'(1));
    write_reg(REG_POWER, '1);
    send_base(rand64());
    settle();
    // power zero gives one
    write_reg(REG_MODULUS, rand64() | field_t'(2));
    write_reg(REG_POWER, '0);
    send_base('1);
    send_base(rand64());
    settle();
    // writes to an unmapped index are dropped
    write_reg(REG_UNMAPPED, rand64());
    send_base(rand64());
    settle();
    // small textbook key
    write_reg(REG_MODULUS, field_t'(3233));
    write_reg(REG_POWER, field_t'(17));
    send_base(field_t'(65));
    send_base('1);
    settle();
  endtask

  task automatic test_full_width();
    write_reg(REG_MODULUS, '1);
    write_reg(REG_POWER, '1);
    send_base('0);
    send_base(field_t'(1));
    send_base('1);
    send_base('1 - field_t'(1));
    settle();
    write_reg(REG_MODULUS, field_t'(3));
    send_base('1);
    settle();
    // base larger than the modulus gets reduced first
    write_reg(REG_MODULUS, field_t'(1000003));
    write_reg(REG_POWER, field_t'(65537));
    send_base('1);
    send_base(field_t'(1000003));
    send_base(field_t'(1000004));
    send_base(field_t'(1) << 63);
    settle();
  endtask

  task automatic test_random_phases();
    int n_items;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 72; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 72; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int setting = 0; setting < 3; setting++) begin
        write_reg(REG_MODULUS, rand_bits($urandom_range(1, FIELD_BITS)));
        if ($urandom_range(11) == 0) write_reg(REG_POWER, rand_bits(FIELD_BITS));
        else write_reg(REG_POWER, rand_bits($urandom_range(1, 16)));
        n_items = $urandom_range(5, 8);
        for (int k = 0; k < n_items; k++) send_base(pick_base());
        settle();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while bases keep coming, so the input must stall
  task automatic test_backpressure();
    write_reg(REG_MODULUS, rand_bits(32));
    write_reg(REG_POWER, rand_bits(4));
    hold_request = 1'b1;
    wait (hold_active);
    for (int k = 0; k < 6; k++) send_base(rand64());
    settle();
  endtask

  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_special_cases();
    test_full_width();
    test_random_phases();
    test_backpressure();

    stop_base();
    wait_drain(DRAIN_LIMIT);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_residues.size() != 0)
      report_mismatch($sformatf("%0d residue words never arrived", expected_residues.size()));
    if (error_count == 0) begin
      $display("** modular_exponentiation: PASSED **");
    end else begin
      $display("** modular_exponentiation: FAILED **");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("** modular_exponentiation: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mexp_pkg.sv
sv/mexp_if.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation.sv
dv/tb_modular_exponentiation.sv
